// ----- rtl/counter_rate_ewma_meter_top_assert.svh -----
`ifndef COUNTER_RATE_EWMA_METER_TOP_ASSERT_SVH
`define COUNTER_RATE_EWMA_METER_TOP_ASSERT_SVH
// Same-cycle implication, sampled on the rising clock edge.
`define CRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on the rising clock edge.
`define CRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/crm_pkg.sv -----
package crm_pkg;

    localparam int NUM_ENTRIES = 256;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);

    localparam logic [63:0] WRAP_SPAN = 64'h0000_0000_FFFF_FFFF;
    localparam logic [31:0] WRAP_MAX  = 32'hFFFF_FFFF;
    localparam logic [16:0] ONE_Q16   = 17'd65536;

    localparam logic [2:0] MODE_HELD   = 3'd0;
    localparam logic [2:0] MODE_FULL   = 3'd1;
    localparam logic [2:0] MODE_RAW    = 3'd2;
    localparam logic [2:0] MODE_SCALED = 3'd3;
    localparam logic [2:0] MODE_FIRST  = 3'd4;

    localparam logic [1:0] REG_MIN    = 2'd0;
    localparam logic [1:0] REG_SCAN   = 2'd1;
    localparam logic [1:0] REG_TC     = 2'd2;
    localparam logic [1:0] REG_WEIGHT = 2'd3;

    localparam logic [23:0] RST_MIN    = 24'd20;
    localparam logic [23:0] RST_SCAN   = 24'd1000;
    localparam logic [23:0] RST_TC     = 24'd5000;
    localparam logic [16:0] RST_WEIGHT = 17'd24186;

    typedef struct packed {
        logic [23:0] min_ms;
        logic [23:0] scan_ms;
        logic [23:0] tc_ms;
        logic [16:0] weight;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic delta;
        logic mulk;
        logic div_init_s;
        logic div_init_w;
        logic div_step;
        logic samp;
        logic wset;
        logic diff;
        logic mul1;
        logic mul2;
        logic ewma;
        logic write;
        logic out;
    } t_cmd;

    typedef struct packed {
        logic first;
        logic held;
        logic raw;
        logic scaled;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/counter_rate_ewma_meter_top.sv -----
// Counter rate meter. Each input beat carries a snapshot of one counter: the
// entry index, the new 64-bit reading and the milliseconds since the last one.
// Each input beat yields exactly one output beat with the rate in Q48.16, the
// update mode, the wrap flag and the running wrap count.
// Registers are to be written over the APB port only while the block is idle;
// the block itself does not enforce this. Items are handled one at a time.
// A first sight or a held rate goes straight to the write; the other modes
// run the bit-serial divider for the sample rate, and a scaled EWMA step runs
// it once more for the scaled weight. The next input beat can be taken in the
// cycle after the result is registered.
// A new input beat is taken while a finished result still waits in the output
// register; if the receiver stalls, the next result waits in the controller
// until that register is free, and no further input is taken meanwhile.
// Reset clears all entry valid bits, the wrap count and both handshakes, and
// loads the default register values; the value and rate memories are not
// cleared, since an entry is used only after its first snapshot wrote it.
module counter_rate_ewma_meter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_entry_index,
    input  logic [63:0] i_new_value,
    input  logic [23:0] i_interval_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_rate_q16,
    output logic [2:0]  o_update_mode,
    output logic        o_wrapped,
    output logic [31:0] o_wrap_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    crm_pkg::t_cfg r_cfg;
    crm_pkg::t_cmd cmd;
    crm_pkg::t_sts sts;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_ms  <= crm_pkg::RST_MIN;
            r_cfg.scan_ms <= crm_pkg::RST_SCAN;
            r_cfg.tc_ms   <= crm_pkg::RST_TC;
            r_cfg.weight  <= crm_pkg::RST_WEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                crm_pkg::REG_MIN:    r_cfg.min_ms  <= pwdata[23:0];
                crm_pkg::REG_SCAN:   r_cfg.scan_ms <= pwdata[23:0];
                crm_pkg::REG_TC:     r_cfg.tc_ms   <= pwdata[23:0];
                crm_pkg::REG_WEIGHT: r_cfg.weight  <= pwdata[16:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            crm_pkg::REG_MIN:    prdata = {8'd0, r_cfg.min_ms};
            crm_pkg::REG_SCAN:   prdata = {8'd0, r_cfg.scan_ms};
            crm_pkg::REG_TC:     prdata = {8'd0, r_cfg.tc_ms};
            crm_pkg::REG_WEIGHT: prdata = {15'd0, r_cfg.weight};
            default:             prdata = '0;
        endcase
    end

    crm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    crm_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_entry_index (i_entry_index),
        .i_new_value   (i_new_value),
        .i_interval_ms (i_interval_ms),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_rate_q16    (o_rate_q16),
        .o_update_mode (o_update_mode),
        .o_wrapped     (o_wrapped),
        .o_wrap_total  (o_wrap_total)
    );

endmodule

// ----- rtl/crm_ram.sv -----
module crm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/crm_dpath.sv -----
module crm_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crm_pkg::t_cfg       i_cfg,
    input  crm_pkg::t_cmd       i_cmd,
    output crm_pkg::t_sts       o_sts,
    input  logic [7:0]          i_entry_index,
    input  logic [63:0]         i_new_value,
    input  logic [23:0]         i_interval_ms,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [63:0]         o_rate_q16,
    output logic [2:0]          o_update_mode,
    output logic                o_wrapped,
    output logic [31:0]         o_wrap_total
);

    logic [crm_pkg::IDX_W-1:0] r_idx;
    logic [63:0]               r_val;
    logic [23:0]               r_ivl;
    logic                      r_first;
    logic [crm_pkg::NUM_ENTRIES-1:0] r_valid;
    logic [63:0]               r_delta;
    logic                      r_wrapped;
    logic [31:0]               r_wrap_cnt;
    logic [2:0]                r_mode;
    logic [73:0]               r_p;
    logic [23:0]               r_rem;
    logic [63:0]               r_dlo;
    logic [63:0]               r_quo;
    logic [23:0]               r_dvs;
    logic [5:0]                r_cnt;
    logic                      r_sat;
    logic [63:0]               r_sample;
    logic [16:0]               r_w;
    logic [63:0]               r_diff;
    logic                      r_neg;
    logic [48:0]               r_pp;
    logic [80:0]               r_acc;
    logic [63:0]               r_rate;
    logic                      r_out_valid;
    logic [63:0]               r_out_rate;
    logic [2:0]                r_out_mode;
    logic                      r_out_wrapped;
    logic [31:0]               r_out_wrap;

    logic [crm_pkg::IDX_W-1:0] rd_addr;
    logic [63:0]               rd_val;
    logic [63:0]               rd_rate;
    logic [16:0]               w_clamp;
    logic                      full;
    logic [24:0]               div_t;
    logic                      div_ge;
    logic [73:0]               prod_k;
    logic [40:0]               prod_w;
    logic [48:0]               pp_hi;
    logic [63:0]               step;

    assign rd_addr = i_cmd.load ? i_entry_index[crm_pkg::IDX_W-1:0] : r_idx;
    assign w_clamp = (i_cfg.weight > crm_pkg::ONE_Q16) ? crm_pkg::ONE_Q16 : i_cfg.weight;
    assign full    = (r_ivl >= i_cfg.scan_ms);
    assign div_t   = {r_rem, r_dlo[63]};
    assign div_ge  = (div_t >= {1'b0, r_dvs});
    assign prod_k  = ({10'd0, r_delta} << 10) - ({10'd0, r_delta} << 4)
                   - ({10'd0, r_delta} << 3);
    assign prod_w  = w_clamp * r_ivl;
    assign pp_hi   = r_diff[63:32] * r_w;
    assign step    = r_acc[79:16];

    assign o_sts.first    = r_first;
    assign o_sts.held     = (r_ivl <= i_cfg.min_ms);
    assign o_sts.raw      = !full && (r_ivl >= i_cfg.tc_ms);
    assign o_sts.scaled   = !full && (r_ivl < i_cfg.tc_ms);
    assign o_sts.div_last = (r_cnt == 6'h3F);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    crm_ram #(.WIDTH(64), .DEPTH(crm_pkg::NUM_ENTRIES)) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write),
        .i_wr_addr (r_idx),
        .i_wr_data (r_val),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_val)
    );

    crm_ram #(.WIDTH(64), .DEPTH(crm_pkg::NUM_ENTRIES)) u_rate_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write),
        .i_wr_addr (r_idx),
        .i_wr_data (r_rate),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_rate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_wrap_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.delta && !r_first && (r_val < rd_val)
                    && (r_wrap_cnt != crm_pkg::WRAP_MAX)) begin
                r_wrap_cnt <= r_wrap_cnt + 32'd1;
            end
            if (i_cmd.out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx   <= i_entry_index[crm_pkg::IDX_W-1:0];
            r_val   <= i_new_value;
            r_ivl   <= i_interval_ms;
            r_first <= !r_valid[i_entry_index[crm_pkg::IDX_W-1:0]];
        end
        if (i_cmd.delta) begin
            if (r_val < rd_val) begin
                r_delta   <= (crm_pkg::WRAP_SPAN - rd_val) + r_val + 64'd1;
                r_wrapped <= !r_first;
            end else begin
                r_delta   <= r_val - rd_val;
                r_wrapped <= 1'b0;
            end
            r_rate <= r_first ? 64'd0 : rd_rate;
            if (r_first) begin
                r_mode <= crm_pkg::MODE_FIRST;
            end else if (o_sts.held) begin
                r_mode <= crm_pkg::MODE_HELD;
            end else if (full) begin
                r_mode <= crm_pkg::MODE_FULL;
            end else if (o_sts.raw) begin
                r_mode <= crm_pkg::MODE_RAW;
            end else begin
                r_mode <= crm_pkg::MODE_SCALED;
            end
        end
        if (i_cmd.mulk) begin
            r_p <= prod_k;
        end
        if (i_cmd.div_init_s) begin
            r_sat <= ({8'd0, r_p[73:48]} >= {10'd0, r_ivl});
            r_rem <= r_p[71:48];
            r_dlo <= {r_p[47:0], 16'd0};
            r_dvs <= r_ivl;
            r_cnt <= '0;
        end
        if (i_cmd.div_init_w) begin
            r_rem <= '0;
            r_dlo <= {23'd0, prod_w};
            r_dvs <= i_cfg.scan_ms;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? 24'(div_t - {1'b0, r_dvs}) : div_t[23:0];
            r_quo <= {r_quo[62:0], div_ge};
            r_dlo <= {r_dlo[62:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_cmd.samp) begin
            r_sample <= r_sat ? '1 : r_quo;
            r_w      <= w_clamp;
            if (o_sts.raw) begin
                r_rate <= r_sat ? '1 : r_quo;
            end
        end
        if (i_cmd.wset) begin
            r_w <= r_quo[16:0];
        end
        if (i_cmd.diff) begin
            r_neg  <= (r_sample < r_rate);
            r_diff <= (r_sample < r_rate) ? r_rate - r_sample : r_sample - r_rate;
        end
        if (i_cmd.mul1) begin
            r_pp <= r_diff[31:0] * r_w;
        end
        if (i_cmd.mul2) begin
            r_acc <= {pp_hi, 32'd0} + {32'd0, r_pp};
        end
        if (i_cmd.ewma) begin
            r_rate <= r_neg ? r_rate - step : r_rate + step;
        end
        if (i_cmd.out) begin
            r_out_rate    <= r_rate;
            r_out_mode    <= r_mode;
            r_out_wrapped <= r_wrapped;
            r_out_wrap    <= r_wrap_cnt;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rate_q16    = r_out_rate;
    assign o_update_mode = r_out_mode;
    assign o_wrapped     = r_out_wrapped;
    assign o_wrap_total  = r_out_wrap;

endmodule

// ----- rtl/crm_ctrl.sv -----
module crm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  crm_pkg::t_sts i_sts,
    output crm_pkg::t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_READ  = 14'b00000000000010,
        S_MULK  = 14'b00000000000100,
        S_DINIT = 14'b00000000001000,
        S_DIVS  = 14'b00000000010000,
        S_SAMP  = 14'b00000000100000,
        S_DIVW  = 14'b00000001000000,
        S_WSET  = 14'b00000010000000,
        S_DIFF  = 14'b00000100000000,
        S_MUL1  = 14'b00001000000000,
        S_MUL2  = 14'b00010000000000,
        S_EWMA  = 14'b00100000000000,
        S_WRITE = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.delta = 1'b1;
                n_state     = (i_sts.first || i_sts.held) ? S_WRITE : S_MULK;
            end
            S_MULK: begin
                o_cmd.mulk = 1'b1;
                n_state    = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init_s = 1'b1;
                n_state          = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SAMP;
                end
            end
            S_SAMP: begin
                o_cmd.samp = 1'b1;
                if (i_sts.raw) begin
                    n_state = S_WRITE;
                end else if (i_sts.scaled) begin
                    o_cmd.div_init_w = 1'b1;
                    n_state          = S_DIVW;
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_DIVW: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_WSET;
                end
            end
            S_WSET: begin
                o_cmd.wset = 1'b1;
                n_state    = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_EWMA;
            end
            S_EWMA: begin
                o_cmd.ewma = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- rtl/crm_chk.sv -----
`include "counter_rate_ewma_meter_top_assert.svh"

module crm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_rate_q16,
    input logic [2:0]  o_update_mode,
    input logic        o_wrapped,
    input logic [31:0] o_wrap_total
);

    `CRM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `CRM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_rate_q16))
    `CRM_ASSERT_NOW(a_first_no_wrap, i_clk, i_rst_n, o_out_valid && (o_update_mode == crm_pkg::MODE_FIRST), !o_wrapped && (o_rate_q16 == 64'd0))
    `CRM_ASSERT_NOW(a_wrap_counted, i_clk, i_rst_n, o_out_valid && o_wrapped, o_wrap_total != 32'd0)

endmodule

bind counter_rate_ewma_meter_top crm_chk u_crm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_rate_q16    (o_rate_q16),
    .o_update_mode (o_update_mode),
    .o_wrapped     (o_wrapped),
    .o_wrap_total  (o_wrap_total)
);

// ----- tb/sv/counter_rate_ewma_meter_top_tb.sv -----
`timescale 1ns / 1ps

module counter_rate_ewma_meter_top_tb;

    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [63:0] rate;
        logic [2:0]  mode;
        logic        wrapped;
        logic [31:0] wrap_total;
    } t_meter_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_entry_index;
    logic [63:0] i_new_value;
    logic [23:0] i_interval_ms;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_rate_q16;
    logic [2:0]  o_update_mode;
    logic        o_wrapped;
    logic [31:0] o_wrap_total;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    counter_rate_ewma_meter_top u_dut (.*);

    // Predictor state.
    logic [23:0] cfg_min_ms;
    logic [23:0] cfg_scan_ms;
    logic [23:0] cfg_tc_ms;
    logic [16:0] cfg_weight;
    logic [63:0] prev_value [crm_pkg::NUM_ENTRIES];
    logic [63:0] prev_rate [crm_pkg::NUM_ENTRIES];
    logic        seen [crm_pkg::NUM_ENTRIES];
    logic [31:0] wrap_seen;

    t_meter_result pending_rates[$];
    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] ewma_update(logic [63:0] old, logic [63:0] samp,
                                                logic [16:0] w);
        logic [63:0]  diff;
        logic [127:0] prod;
        logic [63:0]  step;
        diff = (samp >= old) ? samp - old : old - samp;
        prod = 128'(diff) * 128'(w);
        step = prod[79:16];
        return (samp >= old) ? old + step : old - step;
    endfunction

    function automatic t_meter_result predict_rate(logic [7:0] idx, logic [63:0] val,
                                                   logic [23:0] ivl);
        t_meter_result r;
        logic [16:0]  w;
        logic [63:0]  delta;
        logic [127:0] quot;
        logic [63:0]  samp;
        logic [63:0]  rate;
        logic [40:0]  wprod;
        int           e;
        e = idx % crm_pkg::NUM_ENTRIES;
        w = (cfg_weight > crm_pkg::ONE_Q16) ? crm_pkg::ONE_Q16 : cfg_weight;
        r.wrapped = 1'b0;
        if (!seen[e]) begin
            seen[e] = 1'b1;
            prev_value[e] = val;
            prev_rate[e] = '0;
            r.rate = '0;
            r.mode = crm_pkg::MODE_FIRST;
            r.wrap_total = wrap_seen;
            return r;
        end
        if (val < prev_value[e]) begin
            delta = (crm_pkg::WRAP_SPAN - prev_value[e]) + val + 64'd1;
            r.wrapped = 1'b1;
            if (wrap_seen != crm_pkg::WRAP_MAX) begin
                wrap_seen = wrap_seen + 1;
            end
        end else begin
            delta = val - prev_value[e];
        end
        prev_value[e] = val;
        rate = prev_rate[e];
        if (ivl <= cfg_min_ms) begin
            r.mode = crm_pkg::MODE_HELD;
        end else begin
            quot = (128'(delta) * 128'd65536000) / 128'(ivl);
            samp = (quot[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quot[63:0];
            if (ivl >= cfg_scan_ms) begin
                rate = ewma_update(rate, samp, w);
                r.mode = crm_pkg::MODE_FULL;
            end else if (ivl >= cfg_tc_ms) begin
                rate = samp;
                r.mode = crm_pkg::MODE_RAW;
            end else begin
                wprod = (41'(w) * 41'(ivl)) / 41'(cfg_scan_ms);
                rate = ewma_update(rate, samp, wprod[16:0]);
                r.mode = crm_pkg::MODE_SCALED;
            end
        end
        prev_rate[e] = rate;
        r.rate = rate;
        r.wrap_total = wrap_seen;
        return r;
    endfunction

    task automatic send_snapshot(logic [7:0] idx, logic [63:0] val, logic [23:0] ivl);
        bit idle;
        idle = ($urandom_range(99) < send_idle_pct);
        if (idle) begin
            i_in_valid <= 1'b0;
            while (idle) begin
                @(posedge i_clk);
                idle = ($urandom_range(99) < send_idle_pct);
            end
        end
        pending_rates.push_back(predict_rate(idx, val, ivl));
        i_in_valid <= 1'b1;
        i_entry_index <= idx;
        i_new_value <= val;
        i_interval_ms <= ivl;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            crm_pkg::REG_MIN:    cfg_min_ms = data[23:0];
            crm_pkg::REG_SCAN:   cfg_scan_ms = data[23:0];
            crm_pkg::REG_TC:     cfg_tc_ms = data[23:0];
            crm_pkg::REG_WEIGHT: cfg_weight = data[16:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_rates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
    endtask

    task automatic configure(logic [23:0] mn, logic [23:0] sc, logic [23:0] tc,
                             logic [16:0] w);
        drain();
        write_reg(crm_pkg::REG_MIN, 32'(mn));
        write_reg(crm_pkg::REG_SCAN, 32'(sc));
        write_reg(crm_pkg::REG_TC, 32'(tc));
        write_reg(crm_pkg::REG_WEIGHT, 32'(w));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed;
        send_snapshot(8'd0, 64'd0, 24'd0);
        send_snapshot(8'd0, 64'd1000, 24'd1000);
        send_snapshot(8'd0, 64'd500, 24'd1000);
        send_snapshot(8'd0, 64'd900, 24'd10);
        send_snapshot(8'd0, 64'd2000, 24'd3000);
        send_snapshot(8'd0, 64'd4000, 24'd500);
        send_snapshot(8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
        send_snapshot(8'd255, 64'd0, 24'd1);
        send_snapshot(8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 24'd21);
        send_snapshot(8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
        send_snapshot(8'd1, 64'hFFFF_FFFF, 24'd100);
        send_snapshot(8'd1, 64'd5, 24'd100);
        configure(24'd0, 24'd100, 24'd50, 17'd65536);
        send_snapshot(8'd1, 64'd10, 24'd0);
        send_snapshot(8'd1, 64'd100, 24'd60);
        send_snapshot(8'd1, 64'd200, 24'd30);
        send_snapshot(8'd1, 64'd300, 24'd200);
        configure(24'd5, 24'd0, 24'd1, 17'h1FFFF);
        send_snapshot(8'd1, 64'd1_000_000, 24'd6);
        send_snapshot(8'd1, 64'd5, 24'd7);
        configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 17'd0);
        send_snapshot(8'd1, 64'd9, 24'hFFFFFF);
        send_snapshot(8'd1, 64'd19, 24'hFFFFFE);
    endtask

    task automatic test_random(int count);
        logic [7:0]  idx;
        logic [63:0] val;
        logic [23:0] ivl;
        int          k;
        for (int n = 0; n < count; n++) begin
            idx = 8'($urandom_range(15));
            if ($urandom_range(9) == 0) begin
                idx = 8'($urandom());
            end
            k = $urandom_range(9);
            if (seen[idx] && k < 6) begin
                val = prev_value[idx] + 64'($urandom_range(100000));
            end else if (seen[idx] && k < 8) begin
                val = prev_value[idx] - 64'($urandom_range(100000));
            end else begin
                val = rand64();
            end
            case ($urandom_range(4))
                0: ivl = 24'($urandom_range(40));
                1: ivl = 24'($urandom_range(2000));
                2: ivl = 24'($urandom_range(8000));
                3: ivl = 24'($urandom());
                default: ivl = 24'($urandom_range(1200, 800));
            endcase
            send_snapshot(idx, val, ivl);
        end
    endtask

    task automatic test_random_configs;
        configure(24'd20, 24'd1000, 24'd5000, 17'd24186);
        send_idle_pct = 13;
        recv_idle_pct = 88;
        test_random(400);
        configure(24'($urandom_range(50)), 24'($urandom_range(3000, 1)),
                  24'($urandom_range(6000, 1)), 17'($urandom_range(65536)));
        send_idle_pct = 88;
        recv_idle_pct = 13;
        test_random(400);
        configure(24'd3, 24'd500, 24'd200, 17'($urandom()));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(600);
    endtask

    task automatic test_backpressure;
        drain();
        hold_off = 1'b1;
        test_random(20);
        drain();
    endtask

    always @(posedge i_clk) begin
        if (hold_off) begin
            i_out_ready <= 1'b0;
            repeat (2000) @(posedge i_clk);
            hold_off = 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_meter_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rates.size() == 0) begin
                $error("result beat with nothing expected");
                error_count++;
            end else begin
                exp_r = pending_rates.pop_front();
                if (o_rate_q16 !== exp_r.rate) begin
                    $error("rate_q16 expected %0d actual %0d", exp_r.rate, o_rate_q16);
                    error_count++;
                end
                if (o_update_mode !== exp_r.mode) begin
                    $error("update_mode expected %0d actual %0d", exp_r.mode, o_update_mode);
                    error_count++;
                end
                if (o_wrapped !== exp_r.wrapped) begin
                    $error("wrapped expected %0d actual %0d", exp_r.wrapped, o_wrapped);
                    error_count++;
                end
                if (o_wrap_total !== exp_r.wrap_total) begin
                    $error("wrap_total expected %0d actual %0d", exp_r.wrap_total,
                           o_wrap_total);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("counter_rate_ewma_meter_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_entry_index = '0;
        i_new_value = '0;
        i_interval_ms = '0;
        i_out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b0;
        cfg_min_ms = crm_pkg::RST_MIN;
        cfg_scan_ms = crm_pkg::RST_SCAN;
        cfg_tc_ms = crm_pkg::RST_TC;
        cfg_weight = crm_pkg::RST_WEIGHT;
        wrap_seen = '0;
        for (int e = 0; e < crm_pkg::NUM_ENTRIES; e++) begin
            seen[e] = 1'b0;
            prev_value[e] = '0;
            prev_rate[e] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_configs();
        test_backpressure();
        drain();
        if (error_count == 0) begin
            $display("counter_rate_ewma_meter_top_tb OK");
        end else begin
            $display("counter_rate_ewma_meter_top_tb NOT OK");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/crm_pkg.sv
rtl/crm_ram.sv
rtl/crm_dpath.sv
rtl/crm_ctrl.sv
rtl/counter_rate_ewma_meter_top.sv
rtl/crm_chk.sv
tb/sv/counter_rate_ewma_meter_top_tb.sv
